>>> rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, operation codes and the command/status structs that join
// the controller and the datapath.
// -----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned NumBlocks = 1024;
  localparam int unsigned IdxW      = $clog2(NumBlocks);
  localparam int unsigned CntW      = 11;
  localparam int unsigned BbW       = 13;
  localparam int unsigned RegW      = 11;
  localparam int unsigned SizeW     = 23;
  localparam int unsigned OffW      = 22;
  localparam int unsigned IdW       = 8;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned CfgIdxW   = 1;
  // Divider width: a size plus a block size less one needs one bit more.
  localparam int unsigned QuoW      = SizeW + 1;

  localparam logic [IdW-1:0] ReservedId = 8'd5;

  localparam logic [1:0] ModeInit  = 2'd0;
  localparam logic [1:0] ModeAlloc = 2'd1;
  localparam logic [1:0] ModeFree  = 2'd2;

  localparam logic [1:0] StatDone   = 2'd0;
  localparam logic [1:0] StatNoRoom = 2'd1;
  localparam logic [1:0] StatRange  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgBlockBytes   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgRegionBlocks = 1'd1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpClear, OpDiv, OpReserve, OpChkRoom, OpScan,
    OpTagLeft, OpTagRight, OpTag, OpFreeRd, OpFreeRun, OpFinish
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic done;  // current multi-cycle step finished
    logic fail;  // step ended without success
  } sts_t;

endpackage

>>> rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences the datapath through the steps of init, allocate and free.
// -----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  logic [1:0] mode_i,
  input  logic       res_valid_q_i,
  input  logic       res_taken_i,
  output cmd_t       cmd_o,
  input  sts_t       sts_i,
  output logic       finish_fail_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StClear   = 4'd1;
  localparam logic [3:0] StDivI    = 4'd2;
  localparam logic [3:0] StRes     = 4'd3;
  localparam logic [3:0] StChk     = 4'd4;
  localparam logic [3:0] StDivA    = 4'd5;
  localparam logic [3:0] StScan    = 4'd6;
  localparam logic [3:0] StTagL    = 4'd7;
  localparam logic [3:0] StTagR    = 4'd8;
  localparam logic [3:0] StTag     = 4'd9;
  localparam logic [3:0] StDivF    = 4'd10;
  localparam logic [3:0] StFreeRd  = 4'd11;
  localparam logic [3:0] StFreeRun = 4'd12;
  localparam logic [3:0] StFin     = 4'd13;
  localparam logic [3:0] StBoot    = 4'd14;

  logic [3:0] state_q, state_d;
  logic       fail_q, fail_d;

  // A new request is taken when idle and the result slot is free or leaving.
  assign req_ready_o   = (state_q == StIdle) && (!res_valid_q_i || res_taken_i);
  assign finish_fail_o = fail_q;

  always_comb begin
    state_d   = state_q;
    fail_d    = fail_q;
    cmd_o.op  = OpNone;
    case (state_q)
      StBoot: begin
        // Clearing pass over the whole map after reset.
        cmd_o.op = OpClear;
        if (sts_i.done) state_d = StIdle;
      end
      StIdle: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.op = OpLoad;
          fail_d   = 1'b0;
          case (mode_i)
            ModeInit:  state_d = StClear;
            ModeAlloc: state_d = StChk;
            ModeFree:  state_d = StDivF;
            default:   state_d = StFin;
          endcase
        end
      end
      StClear: begin
        cmd_o.op = OpClear;
        if (sts_i.done) state_d = StDivI;
      end
      StDivI: begin
        cmd_o.op = OpDiv;
        if (sts_i.done) state_d = StRes;
      end
      StRes: begin
        cmd_o.op = OpReserve;
        if (sts_i.done) state_d = StFin;
      end
      StChk: begin
        cmd_o.op = OpChkRoom;
        if (sts_i.done) begin
          if (sts_i.fail) begin
            fail_d  = 1'b1;
            state_d = StFin;
          end else begin
            state_d = StDivA;
          end
        end
      end
      StDivA: begin
        cmd_o.op = OpDiv;
        if (sts_i.done) state_d = StScan;
      end
      StScan: begin
        cmd_o.op = OpScan;
        if (sts_i.done) begin
          if (sts_i.fail) begin
            fail_d  = 1'b1;
            state_d = StFin;
          end else begin
            state_d = StTagL;
          end
        end
      end
      StTagL: begin
        cmd_o.op = OpTagLeft;
        state_d  = StTagR;
      end
      StTagR: begin
        cmd_o.op = OpTagRight;
        state_d  = StTag;
      end
      StTag: begin
        cmd_o.op = OpTag;
        if (sts_i.done) state_d = StFin;
      end
      StDivF: begin
        cmd_o.op = OpDiv;
        if (sts_i.done) state_d = StFreeRd;
      end
      StFreeRd: begin
        cmd_o.op = OpFreeRd;
        if (sts_i.done) begin
          if (sts_i.fail) state_d = StFin;
          else            state_d = StFreeRun;
        end
      end
      StFreeRun: begin
        cmd_o.op = OpFreeRun;
        if (sts_i.done) state_d = StFin;
      end
      StFin: begin
        cmd_o.op = OpFinish;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StBoot;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
    end
  end

endmodule

>>> rtl/core/bba_dpath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Holds the id map, the counters, a restoring divider and the scan pointers.
// The id map is read one entry per cycle with a registered read.
// -----------------------------------------------------------------------------
module bba_dpath
  import bba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic [1:0]       mode_i,
  input  logic [SizeW-1:0] size_bytes_i,
  input  logic [OffW-1:0]  offset_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             finish_fail_i,
  input  logic             res_taken_i,
  output logic             res_valid_o,
  output logic [1:0]       status_o,
  output logic [OffW-1:0]  alloc_offset_o,
  output logic [CntW-1:0]  blocks_used_o
);

  // Configuration registers.
  logic [BbW-1:0]  bb_cfg_q;
  logic [RegW-1:0] rb_cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_cfg_q <= BbW'(16);
      rb_cfg_q <= RegW'(1024);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgBlockBytes)   bb_cfg_q <= cfg_wdata_i[BbW-1:0];
      if (cfg_idx_i == CfgRegionBlocks) rb_cfg_q <= cfg_wdata_i[RegW-1:0];
    end
  end

  // Effective block size and region size.
  logic [BbW-1:0] bb;
  logic [IdxW:0]  rr;
  assign bb = (bb_cfg_q == '0) ? BbW'(1) : bb_cfg_q;
  always_comb begin
    if (rb_cfg_q == '0)                      rr = (IdxW+1)'(1);
    else if (32'(rb_cfg_q) > NumBlocks)      rr = (IdxW+1)'(NumBlocks);
    else                                     rr = (IdxW+1)'(rb_cfg_q);
  end

  // Id memory with a write port and a registered read port.
  logic [IdW-1:0]  mem [NumBlocks];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [IdW-1:0]  mem_wdata, rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // Architectural state.
  logic [CntW-1:0] used_q, used_d;
  logic [IdxW-1:0] lf_q, lf_d;
  // Working registers.
  logic [SizeW-1:0] size_q, size_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [1:0]       mode_q, mode_d;
  logic [IdxW:0]    ptr_q, ptr_d;       // general index / counter
  logic [IdxW:0]    x_q, x_d;           // run start
  logic [IdxW:0]    y_q, y_d;           // run length
  logic [IdxW:0]    d_q, d_d;           // scan steps taken
  logic [QuoW-1:0]  quo_q, quo_d;       // divider quotient, later block need
  logic [BbW:0]     rem_q, rem_d;
  logic [4:0]       dcnt_q, dcnt_d;
  logic             dbusy_q, dbusy_d;
  logic             phase_q, phase_d;   // phase flag of two-phase steps
  logic [IdW-1:0]   left_q, left_d, id_q, id_d;
  logic [1:0]       st_q, st_d;
  logic [OffW-1:0]  ao_q, ao_d;
  logic             rv_q, rv_d;
  logic [OffW+BbW-1:0] mul_q, mul_d;

  // Dividend chosen per mode: init uses rr+bb-1, alloc size+bb-1, free offset.
  logic [QuoW-1:0] dividend;
  always_comb begin
    case (mode_q)
      ModeInit:  dividend = QuoW'(rr) + QuoW'(bb) - QuoW'(1);
      ModeAlloc: dividend = QuoW'(size_q) + QuoW'(bb) - QuoW'(1);
      default:   dividend = QuoW'(off_q);
    endcase
  end

  // Scan helpers.
  logic [IdxW:0] start_idx, scan_x, run_pos, need_w;
  logic          need_big;
  assign start_idx = ((IdxW+1)'(lf_q) + 1'b1 >= rr) ? '0 : (IdxW+1)'(lf_q) + 1'b1;
  assign need_big  = (quo_q > QuoW'(rr));
  assign need_w    = (IdxW+1)'(quo_q);
  always_comb begin
    logic [IdxW+1:0] s;
    s = (IdxW+2)'(start_idx) + (IdxW+2)'(d_q);
    scan_x = (s >= (IdxW+2)'(rr)) ? (IdxW+1)'(s - (IdxW+2)'(rr)) : (IdxW+1)'(s);
  end
  assign run_pos = x_q + y_q;

  logic [IdW-1:0] pick_c;
  always_comb begin
    logic [IdW-1:0] c;
    c = left_q + 1'b1;
    if (c == 0) c = c + 1'b1;
    if (c == rd_q) c = c + 1'b1;
    if (c == 0) c = c + 1'b1;
    pick_c = c;
  end

  always_comb begin
    logic [IdxW+1:0] t;
    logic [BbW:0]    r2;
    used_d = used_q; lf_d = lf_q; size_d = size_q; off_d = off_q; mode_d = mode_q;
    ptr_d = ptr_q; x_d = x_q; y_d = y_q; d_d = d_q; quo_d = quo_q; rem_d = rem_q;
    dcnt_d = dcnt_q; dbusy_d = dbusy_q; phase_d = phase_q; left_d = left_q;
    id_d = id_q; st_d = st_q; ao_d = ao_q; rv_d = rv_q; mul_d = mul_q;
    mem_we = 1'b0; mem_waddr = ptr_q[IdxW-1:0]; mem_wdata = '0;
    mem_raddr = ptr_q[IdxW-1:0];
    sts_o.done = 1'b0; sts_o.fail = 1'b0;
    t = '0; r2 = '0;
    if (res_taken_i) rv_d = 1'b0;
    case (cmd_i.op)
      OpLoad: begin
        size_d = size_bytes_i; off_d = offset_i; mode_d = mode_i;
        ptr_d = '0; dbusy_d = 1'b0; phase_d = 1'b0; st_d = StatDone; ao_d = '0;
        d_d = '0; y_d = '0;
      end
      OpClear: begin
        mem_we = 1'b1; mem_wdata = '0;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == (IdxW+1)'(NumBlocks - 1)) begin
          sts_o.done = 1'b1; ptr_d = '0;
        end
      end
      OpDiv: begin
        // Restoring divider, one quotient bit per cycle.
        if (!dbusy_q) begin
          dbusy_d = 1'b1; quo_d = dividend; rem_d = '0; dcnt_d = '0;
        end else begin
          r2 = {rem_q[BbW-1:0], quo_q[QuoW-1]};
          quo_d = {quo_q[QuoW-2:0], 1'b0};
          if (r2 >= (BbW+1)'(bb)) begin
            r2 = r2 - (BbW+1)'(bb); quo_d[0] = 1'b1;
          end
          rem_d = r2;
          dcnt_d = dcnt_q + 1'b1;
          if (dcnt_q == 5'(QuoW - 1)) begin
            dbusy_d = 1'b0; sts_o.done = 1'b1; ptr_d = '0;
          end
        end
      end
      OpReserve: begin
        // quo holds ceil(r/bb), capped at r.
        if (!phase_q) begin
          phase_d = 1'b1;
          if (quo_q > QuoW'(rr)) quo_d = QuoW'(rr);
        end else if (ptr_q < need_w) begin
          mem_we = 1'b1; mem_wdata = ReservedId; ptr_d = ptr_q + 1'b1;
        end else begin
          sts_o.done = 1'b1; phase_d = 1'b0;
          lf_d = IdxW'(need_w - 1'b1);
          used_d = CntW'(need_w);
        end
      end
      OpChkRoom: begin
        // The used-block product is registered, then compared.
        if (!phase_q) begin
          phase_d = 1'b1;
          mul_d = (OffW+BbW)'(used_q) * (OffW+BbW)'(bb);
          t = '0;
        end else begin
          phase_d = 1'b0; sts_o.done = 1'b1;
          if (mul_q > (OffW+BbW)'(rr) * (OffW+BbW)'(bb) ||
              (OffW+BbW)'(rr) * (OffW+BbW)'(bb) - mul_q < (OffW+BbW)'(size_q))
            sts_o.fail = 1'b1;
        end
      end
      OpScan: begin
        // phase 0: pick a candidate; phase 1: walk run, reading one id a cycle.
        if (!phase_q) begin
          if (d_q >= rr - 1'b1) begin
            sts_o.done = 1'b1; sts_o.fail = 1'b1;
          end else begin
            x_d = scan_x; y_d = '0; phase_d = 1'b1;
            mem_raddr = scan_x[IdxW-1:0];
            ptr_d = scan_x;
          end
        end else begin
          // rd_q holds id at x+y (issued last cycle).
          if (y_q == '0 && rd_q != 0) begin
            phase_d = 1'b0; d_d = d_q + 1'b1;
          end else if (!need_big && y_q == need_w) begin
            phase_d = 1'b0; sts_o.done = 1'b1;
          end else if (!need_big && rd_q == 0 && run_pos < rr) begin
            y_d = y_q + 1'b1;
            mem_raddr = IdxW'(run_pos + 1'b1);
            if (run_pos + 1'b1 >= rr) begin
              if (y_q + 1'b1 != need_w) begin
                phase_d = 1'b0; d_d = d_q + y_q + 1'b1;
              end
            end
          end else begin
            phase_d = 1'b0;
            d_d = (y_q == '0) ? d_q + 1'b1 : d_q + y_q;
          end
        end
      end
      OpTagLeft: begin
        mem_raddr = IdxW'(x_q - 1'b1);
      end
      OpTagRight: begin
        left_d = (x_q == '0) ? '0 : rd_q;
        mem_raddr = IdxW'(run_pos);
        ptr_d = x_q;
        mul_d = (OffW+BbW)'(x_q) * (OffW+BbW)'(bb);
      end
      OpTag: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          id_d = (run_pos < rr) ? pick_c : pick_c;
          if (run_pos >= rr) begin
            id_d = left_q + 1'b1;
            if (id_d == 0) id_d = 8'd1;
          end
        end else if (ptr_q < run_pos) begin
          mem_we = 1'b1; mem_wdata = id_q; ptr_d = ptr_q + 1'b1;
        end else begin
          phase_d = 1'b0; sts_o.done = 1'b1;
          t = (IdxW+2)'(x_q) + (IdxW+2)'(need_w) + (IdxW+2)'(rr) + (IdxW+2)'(rr)
              - (IdxW+2)'(2);
          while_mod: begin
            if (t >= (IdxW+2)'(rr)) t = t - (IdxW+2)'(rr);
            if (t >= (IdxW+2)'(rr)) t = t - (IdxW+2)'(rr);
            if (t >= (IdxW+2)'(rr)) t = t - (IdxW+2)'(rr);
          end
          lf_d = IdxW'(t);
          used_d = used_q + CntW'(y_q);
          ao_d = mul_q[OffW-1:0];
        end
      end
      OpFreeRd: begin
        if (!phase_q) begin
          if (quo_q >= QuoW'(rr)) begin
            sts_o.done = 1'b1; sts_o.fail = 1'b1; st_d = StatRange;
          end else begin
            phase_d = 1'b1; ptr_d = (IdxW+1)'(quo_q);
            mem_raddr = IdxW'(quo_q); y_d = '0;
          end
        end else begin
          id_d = rd_q; phase_d = 1'b0; sts_o.done = 1'b1;
          mem_raddr = ptr_q[IdxW-1:0];
        end
      end
      OpFreeRun: begin
        // rd_q holds id at ptr.
        if (ptr_q < rr && rd_q == id_q) begin
          mem_we = 1'b1; mem_wdata = '0;
          ptr_d = ptr_q + 1'b1; y_d = y_q + 1'b1;
          mem_raddr = IdxW'(ptr_q + 1'b1);
          phase_d = 1'b1;
        end else if (phase_q && ptr_q < rr) begin
          // A mismatch right after a write on ptr-1 re-reads ptr before ending the run.
          phase_d = 1'b0; mem_raddr = ptr_q[IdxW-1:0];
        end else begin
          phase_d = 1'b0; sts_o.done = 1'b1;
          used_d = used_q - CntW'(y_q);
        end
      end
      OpFinish: begin
        if (finish_fail_i) begin
          st_d = StatNoRoom; ao_d = '0;
        end
        rv_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0; lf_q <= '0; dbusy_q <= 1'b0; phase_q <= 1'b0; rv_q <= 1'b0;
      ptr_q <= '0;
    end else begin
      used_q <= used_d; lf_q <= lf_d; dbusy_q <= dbusy_d; phase_q <= phase_d;
      rv_q <= rv_d; ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d; off_q <= off_d; mode_q <= mode_d;
    x_q <= x_d; y_q <= y_d; d_q <= d_d; quo_q <= quo_d; rem_q <= rem_d;
    dcnt_q <= dcnt_d; left_q <= left_d; id_q <= id_d; st_q <= st_d;
    ao_q <= ao_d; mul_q <= mul_d;
  end

  assign res_valid_o    = rv_q;
  assign status_o       = st_q;
  assign alloc_offset_o = (st_q == StatDone) ? ao_q : '0;
  assign blocks_used_o  = used_q;

endmodule

>>> rtl/core/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator unit
// Top level: a controller and a datapath managing one block region.
// -----------------------------------------------------------------------------
// Usage: a request arrives on the input channel (valid/ready) with a mode:
// init, allocate or free. One result per request leaves on the output
// channel (valid/ready) carrying status, offset and used block count.
// Requests are handled one at a time. The id memory is read one entry per
// cycle: init clears all 1024 entries, divides and then writes the reserved
// blocks; allocate checks for room, divides, scans the region and tags the
// run it found; free divides, reads the id at the offset and clears the run
// that carries it. After reset a clearing pass empties the map while the
// input is held not ready; the register defaults are 16 bytes per block and
// 1024 blocks. The result waits in an output register while the receiver
// stalls; a new request is accepted in the cycle the waiting result is
// taken.
// -----------------------------------------------------------------------------
module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [SizeW-1:0]   size_bytes_i,
  input  logic [OffW-1:0]    offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [OffW-1:0]    alloc_offset_o,
  output logic [CntW-1:0]    blocks_used_o
);

  cmd_t cmd;
  sts_t sts;
  logic fin_fail;
  logic taken;

  assign taken = out_valid_o && out_ready_i;

  // Sequencing of each request.
  bba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_o   (in_ready_o),
    .mode_i        (mode_i),
    .res_valid_q_i (out_valid_o),
    .res_taken_i   (taken),
    .cmd_o         (cmd),
    .sts_i         (sts),
    .finish_fail_o (fin_fail)
  );

  // Map storage and arithmetic.
  bba_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .size_bytes_i   (size_bytes_i),
    .offset_i       (offset_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .finish_fail_i  (fin_fail),
    .res_taken_i    (taken),
    .res_valid_o    (out_valid_o),
    .status_o       (status_o),
    .alloc_offset_o (alloc_offset_o),
    .blocks_used_o  (blocks_used_o)
  );

endmodule

>>> test/bitmap_block_allocator_unit_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap block allocator unit testbench
// Drives init, allocate, free and no-operation requests under several block
// size and region size settings. A scoreboard predicts each result from its
// own copy of the id map and compares the results in order, field by field.
// -----------------------------------------------------------------------------
module bitmap_block_allocator_unit_test;
  import bba_pkg::*;

  localparam logic [1:0] ModeNop   = 2'd3;
  localparam int         CycleLimit = 10000000;
  localparam int         HoldCycles = 3000;

  typedef struct {
    logic [1:0]      status;
    logic [OffW-1:0] offset;
    logic [CntW-1:0] used;
  } alloc_result_t;

  // Scoreboard: keeps its own copy of the allocator state and the queue of
  // results still to arrive.
  class alloc_scoreboard;
    logic [IdW-1:0] ids[NumBlocks];
    int unsigned    used_cnt;
    int unsigned    hint;
    int unsigned    blk_bytes;
    int unsigned    reg_blocks;
    alloc_result_t  awaited[$];
    int unsigned    live_offsets[$];
    int             mismatches;

    function new();
      foreach (ids[i]) ids[i] = '0;
      used_cnt   = 0;
      hint       = 0;
      blk_bytes  = 16;
      reg_blocks = 1024;
      mismatches = 0;
    endfunction

    function void set_config(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CfgBlockBytes) blk_bytes = data;
      else reg_blocks = data[RegW-1:0];
    endfunction

    function longint eff_bytes();
      return (blk_bytes == 0) ? 1 : blk_bytes;
    endfunction

    function longint eff_region();
      if (reg_blocks == 0) return 1;
      if (reg_blocks > NumBlocks) return NumBlocks;
      return reg_blocks;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(logic [1:0] mode, logic [SizeW-1:0] size,
                               logic [OffW-1:0] off);
      alloc_result_t  res;
      longint         bb, r, need, start, d, x, y, rsv;
      logic [IdW-1:0] left, right, tag;
      bb = eff_bytes();
      r  = eff_region();
      res.status = StatDone;
      res.offset = '0;
      case (mode)
        ModeInit: begin
          rsv = (r + bb - 1) / bb;
          if (rsv > r) rsv = r;
          foreach (ids[i]) ids[i] = (i < rsv) ? ReservedId : '0;
          hint     = rsv - 1;
          used_cnt = rsv & 'h7FF;
        end
        ModeAlloc: begin
          res.status = StatNoRoom;
          if (!(longint'(used_cnt) * bb > r * bb ||
                r * bb - longint'(used_cnt) * bb < longint'(size))) begin
            need  = (longint'(size) + bb - 1) / bb;
            start = (longint'(hint) + 1 >= r) ? 0 : hint + 1;
            d     = 0;
            // Circular scan; a run that is too short is skipped as a whole.
            while (d < r - 1 && res.status == StatNoRoom) begin
              x = (start + d) % r;
              y = 0;
              if (ids[x] != 0) begin
                d++;
              end else begin
                while (y < need && x + y < r && ids[x + y] == 0) y++;
                if (y == need) begin
                  left  = (x == 0) ? '0 : ids[x - 1];
                  right = (x + y < r) ? ids[x + y] : '0;
                  tag   = left + 8'd1;
                  while (tag == right || tag == 0) tag = tag + 8'd1;
                  for (longint z = 0; z < y; z++) ids[x + z] = tag;
                  hint       = (x + need + 2 * r - 2) % r;
                  used_cnt   = (used_cnt + y) & 'h7FF;
                  res.status = StatDone;
                  res.offset = x * bb;
                  if (need > 0) live_offsets.push_back(res.offset);
                end else begin
                  d += y;
                end
              end
            end
          end
        end
        ModeFree: begin
          x = longint'(off) / bb;
          if (x >= r) begin
            res.status = StatRange;
          end else begin
            tag = ids[x];
            y   = x;
            while (y < r && ids[y] == tag) begin
              ids[y] = '0;
              y++;
            end
            used_cnt = (used_cnt - (y - x)) & 'h7FF;
          end
        end
        default: ;
      endcase
      res.used = used_cnt[CntW-1:0];
      awaited.push_back(res);
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(logic [1:0] st, logic [OffW-1:0] off,
                               logic [CntW-1:0] used);
      alloc_result_t exp_r;
      if (awaited.size() == 0) begin
        report("unexpected result, status", -1, st);
        return;
      end
      exp_r = awaited.pop_front();
      if (st !== exp_r.status) report("status", exp_r.status, st);
      if (off !== exp_r.offset) report("alloc_offset", exp_r.offset, off);
      if (used !== exp_r.used) report("blocks_used", exp_r.used, used);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic [SizeW-1:0]   size_bytes_i;
  logic [OffW-1:0]    offset_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [OffW-1:0]    alloc_offset_o;
  logic [CntW-1:0]    blocks_used_o;

  alloc_scoreboard sb = new();
  int              sent_cnt  = 0;
  int              cycle_cnt = 0;
  bit              hold_req  = 1'b0;
  int              hold_left = 0;

  bitmap_block_allocator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Idling regime follows the number of requests sent so far.
  function int regime();
    return (sent_cnt < 190) ? 0 : (sent_cnt < 380) ? 1 : 2;
  endfunction

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check taken results, stall at random or for a long hold.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(status_o, alloc_offset_o, blocks_used_o);
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (regime())
        0:       out_ready_i <= ($urandom_range(0, 99) >= 87);
        1:       out_ready_i <= ($urandom_range(0, 99) >= 21);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  task automatic send_request(logic [1:0] mode, logic [SizeW-1:0] size,
                              logic [OffW-1:0] off);
    int idle_pct;
    idle_pct = (regime() == 0) ? 21 : (regime() == 1) ? 87 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    size_bytes_i <= size;
    offset_i     <= off;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(mode, size, off);
    sent_cnt++;
  endtask

  // Waits until every predicted result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.set_config(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_request();
    int              pick, k;
    longint          bb, r;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  off;
    bb   = sb.eff_bytes();
    r    = sb.eff_region();
    pick = $urandom_range(0, 99);
    size = $urandom;
    off  = $urandom;
    if (pick < 3) begin
      send_request(ModeInit, size, off);
    end else if (pick < 55) begin
      k = $urandom_range(0, 9);
      if (k < 8) size = $urandom_range(0, bb * $urandom_range(1, 4));
      else if (k == 8) size = $urandom_range(0, r * bb);
      send_request(ModeAlloc, size, off);
    end else if (pick < 93) begin
      k = $urandom_range(0, 19);
      if (k < 12 && sb.live_offsets.size() > 0) begin
        k   = $urandom_range(0, sb.live_offsets.size() - 1);
        off = sb.live_offsets[k] + $urandom_range(0, bb - 1);
        sb.live_offsets.delete(k);
      end else if (k < 17) begin
        off = $urandom_range(0, r * bb - 1);
      end
      send_request(ModeFree, size, off);
    end else begin
      send_request(ModeNop, size, off);
    end
  endtask

  initial begin
    int unsigned bb_set[8] = '{16, 1, 0, 8191, 4096, 3, 2, 16};
    int unsigned rb_set[8] = '{1024, 8, 0, 1024, 2047, 5, 64, 1024};
    int          per_phase;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgBlockBytes;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    mode_i       = ModeInit;
    size_bytes_i = '0;
    offset_i     = '0;
    out_ready_i  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset settings, starting from the reset map.
    send_request(ModeAlloc, 23'd40, '0);
    send_request(ModeFree, '0, '0);
    send_request(ModeInit, '1, '1);
    send_request(ModeAlloc, 23'd0, '0);
    send_request(ModeAlloc, 23'd1, '0);
    send_request(ModeAlloc, 23'd16, '0);
    send_request(ModeAlloc, 23'd17, '0);
    send_request(ModeAlloc, 23'd4194304, '0);
    send_request(ModeAlloc, 23'h7FFFFF, '0);
    send_request(ModeFree, '0, 22'd0);
    send_request(ModeFree, '0, 22'd16383);
    send_request(ModeFree, '0, 22'd16384);
    send_request(ModeFree, '0, 22'h3FFFFF);
    send_request(ModeNop, '1, '1);
    send_request(ModeFree, '0, 22'd2000);
    send_request(ModeAlloc, 23'd15000, '0);
    send_request(ModeAlloc, 23'd16000, '0);
    send_request(ModeInit, '0, '0);
    send_request(ModeAlloc, 23'd16000, '0);
    send_request(ModeAlloc, 23'd48, '0);
    drain();

    // Random phases over several settings, each opened by an init.
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        write_reg(CfgBlockBytes, bb_set[p]);
        write_reg(CfgRegionBlocks, rb_set[p]);
      end
      send_request(ModeInit, '0, '0);
      if (p == 2) hold_req = 1'b1;
      per_phase = (rb_set[p] >= 1024 || rb_set[p] == 0) ? 50 : 90;
      if (p == 7) per_phase = 80;
      repeat (per_phase) random_request();
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dpath.sv
rtl/core/bitmap_block_allocator_unit.sv
test/bitmap_block_allocator_unit_test.sv
